// ===== rtl/rsct_pkg.sv =====
// ----------------------------------------------------------------------------
// rsct_pkg
// Shared types and constants for the remapped secure cache tag store.
// ----------------------------------------------------------------------------
package rsct_pkg;

    localparam int WAYS_DEF         = 64;
    localparam int LINE_BYTES_DEF   = 64;
    localparam int ADDR_BITS_DEF    = 48;
    localparam int CONTEXT_BITS_DEF = 8;

    localparam int TAG_W     = 36;
    localparam int IDX_W     = 10;
    localparam int EXTRA_W   = 3;
    localparam int EXTRA_MAX = 4;
    localparam int LFSR_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_FILL   = 2'd1,
        KIND_INVAL  = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXTRA_BITS = 1'b0,
        CFG_SEED       = 1'b1
    } cfg_reg_t;

endpackage

// ===== rtl/remapped_secure_cache_tags_core.sv =====
// ----------------------------------------------------------------------------
// remapped_secure_cache_tags_core
// Fully associative tag store keyed by context, secure bit and line index.
// ----------------------------------------------------------------------------
// Timing: an accepted start is captured in the request register; done and
//   the result beat are then driven from the result register after it.
// Throughput: one beat per cycle; busy stays low, every way is compared
//   in parallel in the single stage between the request and result registers.
// Reset: valid bits clear, extra index bits go to 0, LFSR loads 1.
//   Tag, context, secure and index entries are not cleared.
module remapped_secure_cache_tags_core #(
    parameter int WAYS         = rsct_pkg::WAYS_DEF,
    parameter int LINE_BYTES   = rsct_pkg::LINE_BYTES_DEF,
    parameter int ADDR_BITS    = rsct_pkg::ADDR_BITS_DEF,
    parameter int CONTEXT_BITS = rsct_pkg::CONTEXT_BITS_DEF,
    localparam int WAY_W       = $clog2(WAYS)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rsct_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [rsct_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     kind,
    input  logic [ADDR_BITS-1:0]           address,
    input  logic [CONTEXT_BITS-1:0]        context_id,
    input  logic                           secure,
    input  logic                           global_access,
    output logic                           done,
    output logic                           hit,
    output logic [WAY_W-1:0]               way,
    output logic                           evicted,
    output logic [rsct_pkg::TAG_W-1:0]     evicted_tag,
    output logic [rsct_pkg::IDX_W-1:0]     evicted_index,
    output logic [CONTEXT_BITS-1:0]        evicted_context
);

    localparam int OFF_BITS = $clog2(LINE_BYTES);
    localparam int IDXB_W   = $clog2(WAY_W + rsct_pkg::EXTRA_MAX + 1);
    localparam int AX_W     = ADDR_BITS + rsct_pkg::TAG_W;

    function automatic logic [rsct_pkg::LFSR_W-1:0] lfsr_step(
        input logic [rsct_pkg::LFSR_W-1:0] s
    );
        logic fb;
        fb = s[0] ^ s[2] ^ s[3] ^ s[5];
        return {fb, s[rsct_pkg::LFSR_W-1:1]};
    endfunction

    // configuration
    logic [rsct_pkg::EXTRA_W-1:0] extra_reg;
    logic [rsct_pkg::LFSR_W-1:0]  lfsr_reg;
    logic [rsct_pkg::LFSR_W-1:0]  lfsr_next;

    // request register
    logic                    req_vld_reg;
    rsct_pkg::kind_t         req_kind_reg;
    logic [ADDR_BITS-1:0]    req_addr_reg;
    logic [CONTEXT_BITS-1:0] req_ctx_reg;
    logic                    req_sec_reg;
    logic                    req_glob_reg;

    // line state
    logic [WAYS-1:0]                  line_valid_reg;
    logic [rsct_pkg::TAG_W-1:0]       line_tag_reg [WAYS];
    logic [CONTEXT_BITS-1:0]          line_ctx_reg [WAYS];
    logic                             line_sec_reg [WAYS];
    logic [rsct_pkg::IDX_W-1:0]       line_idx_reg [WAYS];

    // result register
    logic                         done_reg,  done_next;
    logic                         hit_reg,   hit_next;
    logic [WAY_W-1:0]             way_reg,   way_next;
    logic                         evict_reg, evict_next;
    logic [rsct_pkg::TAG_W-1:0]   etag_reg,  etag_next;
    logic [rsct_pkg::IDX_W-1:0]   eidx_reg,  eidx_next;
    logic [CONTEXT_BITS-1:0]      ectx_reg,  ectx_next;

    // request decode
    logic [rsct_pkg::EXTRA_W-1:0] extra_eff;
    logic [IDXB_W-1:0]            idx_bits;
    logic [AX_W-1:0]              addr_off;
    logic [AX_W-1:0]              addr_tag;
    logic [rsct_pkg::IDX_W-1:0]   idx_mask;
    logic [rsct_pkg::IDX_W-1:0]   req_idx;
    logic [rsct_pkg::TAG_W-1:0]   req_tag;
    logic [CONTEXT_BITS-1:0]      req_ctx;

    logic [WAYS-1:0]      key_match;
    logic                 key_any;
    logic [WAY_W-1:0]     key_way;
    logic                 tag_hit;
    logic [rsct_pkg::LFSR_W-1:0] lfsr_adv;
    logic [WAY_W-1:0]     vict_way;
    logic                 do_fill;
    logic                 do_inval;

    assign busy = 1'b0;

    always_comb
    begin
        extra_eff = (extra_reg > rsct_pkg::EXTRA_W'(rsct_pkg::EXTRA_MAX))
                    ? rsct_pkg::EXTRA_W'(rsct_pkg::EXTRA_MAX) : extra_reg;
        idx_bits  = IDXB_W'(WAY_W) + IDXB_W'(extra_eff);
        addr_off  = {{rsct_pkg::TAG_W{1'b0}}, req_addr_reg} >> OFF_BITS;
        addr_tag  = addr_off >> idx_bits;
        idx_mask  = ~({rsct_pkg::IDX_W{1'b1}} << idx_bits);
        req_idx   = addr_off[rsct_pkg::IDX_W-1:0] & idx_mask;
        req_tag   = addr_tag[rsct_pkg::TAG_W-1:0];
        req_ctx   = req_glob_reg ? '0 : req_ctx_reg;
    end

    // key compare across all ways; at most one valid line holds a key
    always_comb
    begin
        key_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            key_match[w] = line_valid_reg[w] && (line_ctx_reg[w] == req_ctx) &&
                           (line_sec_reg[w] == req_sec_reg) &&
                           (line_idx_reg[w] == req_idx);
            key_way = key_way | (key_match[w] ? WAY_W'(w) : '0);
        end
        key_any = |key_match;
    end

    always_comb
    begin
        tag_hit  = key_any && (line_tag_reg[key_way] == req_tag);
        lfsr_adv = lfsr_step(lfsr_reg);
        vict_way = key_any ? key_way : lfsr_adv[WAY_W-1:0];
        do_fill  = req_vld_reg && (req_kind_reg == rsct_pkg::KIND_FILL);
        do_inval = req_vld_reg && (req_kind_reg == rsct_pkg::KIND_INVAL) && tag_hit;
    end

    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (cfg_we && (cfg_addr == rsct_pkg::CFG_SEED))
        begin
            lfsr_next = (cfg_wdata == '0) ? rsct_pkg::LFSR_W'(1)
                                          : cfg_wdata[rsct_pkg::LFSR_W-1:0];
        end
        else if (do_fill && !key_any)
        begin
            lfsr_next = lfsr_adv;
        end
    end

    always_comb
    begin
        done_next  = req_vld_reg;
        hit_next   = 1'b0;
        way_next   = '0;
        evict_next = 1'b0;
        etag_next  = '0;
        eidx_next  = '0;
        ectx_next  = '0;
        case (req_kind_reg) inside
            rsct_pkg::KIND_LOOKUP, rsct_pkg::KIND_INVAL:
            begin
                hit_next = tag_hit;
                way_next = tag_hit ? key_way : '0;
            end
            rsct_pkg::KIND_FILL:
            begin
                way_next   = vict_way;
                evict_next = line_valid_reg[vict_way];
                if (line_valid_reg[vict_way])
                begin
                    etag_next = line_tag_reg[vict_way];
                    eidx_next = line_idx_reg[vict_way];
                    ectx_next = line_ctx_reg[vict_way];
                end
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extra_reg      <= '0;
            lfsr_reg       <= rsct_pkg::LFSR_W'(1);
            req_vld_reg    <= 1'b0;
            done_reg       <= 1'b0;
            line_valid_reg <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_addr == rsct_pkg::CFG_EXTRA_BITS))
            begin
                extra_reg <= cfg_wdata[rsct_pkg::EXTRA_W-1:0];
            end
            lfsr_reg    <= lfsr_next;
            req_vld_reg <= start && !busy;
            done_reg    <= done_next;
            if (do_fill)
            begin
                line_valid_reg[vict_way] <= 1'b1;
            end
            else if (do_inval)
            begin
                line_valid_reg[key_way] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_kind_reg <= rsct_pkg::kind_t'(kind);
            req_addr_reg <= address;
            req_ctx_reg  <= context_id;
            req_sec_reg  <= secure;
            req_glob_reg <= global_access;
        end
        if (do_fill)
        begin
            line_tag_reg[vict_way] <= req_tag;
            line_ctx_reg[vict_way] <= req_ctx;
            line_sec_reg[vict_way] <= req_sec_reg;
            line_idx_reg[vict_way] <= req_idx;
        end
        hit_reg   <= hit_next;
        way_reg   <= way_next;
        evict_reg <= evict_next;
        etag_reg  <= etag_next;
        eidx_reg  <= eidx_next;
        ectx_reg  <= ectx_next;
    end

    assign done            = done_reg;
    assign hit             = hit_reg;
    assign way             = way_reg;
    assign evicted         = evict_reg;
    assign evicted_tag     = etag_reg;
    assign evicted_index   = eidx_reg;
    assign evicted_context = ectx_reg;

endmodule

// ===== rtl/rsct_checker.sv =====
// ----------------------------------------------------------------------------
// rsct_checker
// Port-level checks for the remapped secure cache tag store.
// ----------------------------------------------------------------------------
module rsct_checker #(
    parameter int WAYS         = rsct_pkg::WAYS_DEF,
    parameter int CONTEXT_BITS = rsct_pkg::CONTEXT_BITS_DEF,
    localparam int WAY_W       = $clog2(WAYS)
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [1:0]                     kind,
    input logic                           done,
    input logic                           hit,
    input logic [WAY_W-1:0]               way,
    input logic                           evicted,
    input logic [rsct_pkg::TAG_W-1:0]     evicted_tag,
    input logic [rsct_pkg::IDX_W-1:0]     evicted_index,
    input logic [CONTEXT_BITS-1:0]        evicted_context
);

    // every accepted beat yields exactly one result through the request and result registers
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted beat gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##2 !done)
        else $error("result without accepted beat");

    a_hit_not_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> !evicted)
        else $error("hit and eviction in one result");

    a_evict_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !evicted) |->
            (evicted_tag == '0) && (evicted_index == '0) && (evicted_context == '0))
        else $error("eviction fields set without eviction");

    a_miss_way: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit && !evicted && ($past(kind, 2) != rsct_pkg::KIND_FILL)) |->
            (way == '0))
        else $error("way nonzero on a miss");

endmodule

bind remapped_secure_cache_tags_core rsct_checker #(
    .WAYS         (WAYS),
    .CONTEXT_BITS (CONTEXT_BITS)
) u_rsct_checker (.*);

// ===== sim/remapped_secure_cache_tags_core_tb.sv =====
// ----------------------------------------------------------------------------
// remapped_secure_cache_tags_core_tb
// Self-checking bench for the remapped secure cache tag store. A queue-fed
// driver issues lookup, fill, invalidate and no-op beats; a monitor keeps a
// shadow tag store (valid bits, keys, tags and the replacement LFSR), works
// out every expected result and compares it field by field with the block.
// Phases change the extra index bits and the seed, and the sender's idling.
// ----------------------------------------------------------------------------
module remapped_secure_cache_tags_core_tb;

    localparam int WAYS_DEF         = rsct_pkg::WAYS_DEF;
    localparam int LINE_BYTES_DEF   = rsct_pkg::LINE_BYTES_DEF;
    localparam int ADDR_BITS_DEF    = rsct_pkg::ADDR_BITS_DEF;
    localparam int CONTEXT_BITS_DEF = rsct_pkg::CONTEXT_BITS_DEF;
    localparam int TAG_W            = rsct_pkg::TAG_W;
    localparam int IDX_W            = rsct_pkg::IDX_W;
    localparam int EXTRA_W          = rsct_pkg::EXTRA_W;
    localparam int EXTRA_MAX        = rsct_pkg::EXTRA_MAX;
    localparam int LFSR_W           = rsct_pkg::LFSR_W;
    localparam int CFG_W            = rsct_pkg::CFG_W;
    localparam int CFG_IDX_W        = rsct_pkg::CFG_IDX_W;

    localparam int WAY_W     = $clog2(WAYS_DEF);
    localparam int OFF_W     = $clog2(LINE_BYTES_DEF);
    localparam int POOL_KEYS = 24;
    localparam int POOL_TAGS = 3;

    typedef struct {
        logic [1:0]                  op;
        logic [ADDR_BITS_DEF-1:0]    addr;
        logic [CONTEXT_BITS_DEF-1:0] ctx_id;
        logic                        sec;
        logic                        glob;
        bit                          drain_first;
    } req_t;

    typedef struct {
        logic                        hit;
        logic [WAY_W-1:0]            way;
        logic                        evicted;
        logic [TAG_W-1:0]            ev_tag;
        logic [IDX_W-1:0]            ev_index;
        logic [CONTEXT_BITS_DEF-1:0] ev_ctx;
    } resp_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_addr = '0;
    logic [CFG_W-1:0]            cfg_wdata = '0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [1:0]                  kind = '0;
    logic [ADDR_BITS_DEF-1:0]    address = '0;
    logic [CONTEXT_BITS_DEF-1:0] context_id = '0;
    logic                        secure = 1'b0;
    logic                        global_access = 1'b0;
    logic                        done;
    logic                        hit;
    logic [WAY_W-1:0]            way;
    logic                        evicted;
    logic [TAG_W-1:0]            evicted_tag;
    logic [IDX_W-1:0]            evicted_index;
    logic [CONTEXT_BITS_DEF-1:0] evicted_context;

    remapped_secure_cache_tags_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .address         (address),
        .context_id      (context_id),
        .secure          (secure),
        .global_access   (global_access),
        .done            (done),
        .hit             (hit),
        .way             (way),
        .evicted         (evicted),
        .evicted_tag     (evicted_tag),
        .evicted_index   (evicted_index),
        .evicted_context (evicted_context)
    );

    always #2 clk = ~clk;

    // shadow tag store
    bit                        line_ok  [WAYS_DEF];
    bit [TAG_W-1:0]            line_tag [WAYS_DEF];
    bit [CONTEXT_BITS_DEF-1:0] line_ctx [WAYS_DEF];
    bit                        line_sec [WAYS_DEF];
    bit [IDX_W-1:0]            line_idx [WAYS_DEF];
    bit [EXTRA_W-1:0]          map_extra = '0;
    bit [LFSR_W-1:0]           victim_lfsr = 16'd1;

    req_t  req_backlog[$];
    resp_t tag_results[$];

    bit    beat_taken = 1'b0;
    int    idle_pct = 0;
    int    err_count = 0;
    int    beats_seen = 0;
    int    hits_seen = 0;
    int    evicts_seen = 0;
    int    settings_seen = 0;

    // stimulus pool
    int                        gen_nidx = 6;
    int                        phase_pushed = 0;
    int                        drain_at = -1;
    bit [CONTEXT_BITS_DEF-1:0] pool_ctx  [POOL_KEYS];
    bit                        pool_sec  [POOL_KEYS];
    bit                        pool_glob [POOL_KEYS];
    bit [IDX_W-1:0]            pool_idx  [POOL_KEYS];
    bit [ADDR_BITS_DEF-1:0]    pool_tag  [POOL_KEYS][POOL_TAGS];

    function automatic resp_t predict_access(req_t r);
        resp_t                     o;
        int                        match_way;
        int                        n_idx;
        bit [CONTEXT_BITS_DEF-1:0] c;
        bit [IDX_W-1:0]            ix;
        bit [TAG_W-1:0]            tg;
        bit                        fb;
        o = '{default: '0};
        n_idx = WAY_W + ((map_extra > EXTRA_MAX) ? EXTRA_MAX : int'(map_extra));
        c = r.glob ? '0 : r.ctx_id;
        ix = IDX_W'((r.addr >> OFF_W) & ((48'd1 << n_idx) - 48'd1));
        tg = TAG_W'(r.addr >> (OFF_W + n_idx));
        match_way = -1;
        for (int i = WAYS_DEF - 1; i >= 0; i--)
            if (line_ok[i] && line_ctx[i] == c && line_sec[i] == r.sec && line_idx[i] == ix)
                match_way = i;
        case (rsct_pkg::kind_t'(r.op)) inside
            rsct_pkg::KIND_LOOKUP, rsct_pkg::KIND_INVAL:
            begin
                if (match_way >= 0 && line_tag[match_way] == tg)
                begin
                    o.hit = 1'b1;
                    o.way = WAY_W'(match_way);
                    if (rsct_pkg::kind_t'(r.op) == rsct_pkg::KIND_INVAL)
                        line_ok[match_way] = 1'b0;
                end
            end
            rsct_pkg::KIND_FILL:
            begin
                if (match_way < 0)
                begin
                    fb = victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5];
                    victim_lfsr = {fb, victim_lfsr[LFSR_W-1:1]};
                    match_way = int'(victim_lfsr[WAY_W-1:0]);
                end
                o.way = WAY_W'(match_way);
                if (line_ok[match_way])
                begin
                    o.evicted  = 1'b1;
                    o.ev_tag   = line_tag[match_way];
                    o.ev_index = line_idx[match_way];
                    o.ev_ctx   = line_ctx[match_way];
                end
                line_ok[match_way]  = 1'b1;
                line_tag[match_way] = tg;
                line_ctx[match_way] = c;
                line_sec[match_way] = r.sec;
                line_idx[match_way] = ix;
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic note_mismatch(string field, logic [63:0] got, logic [63:0] want);
        if (err_count < 40)
            $display("MISMATCH @%0t %s: got %0h want %0h", $realtime, field, got, want);
        err_count++;
    endtask

    // driver
    always @(negedge clk)
    begin
        req_t nxt;
        if (rst_n && (!start || beat_taken))
        begin
            if (req_backlog.size() != 0 &&
                !(req_backlog[0].drain_first && (start || tag_results.size() != 0)) &&
                $urandom_range(99) >= idle_pct)
            begin
                nxt = req_backlog.pop_front();
                start         <= 1'b1;
                kind          <= nxt.op;
                address       <= nxt.addr;
                context_id    <= nxt.ctx_id;
                secure        <= nxt.sec;
                global_access <= nxt.glob;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor and predictor
    always @(posedge clk)
    begin
        resp_t want;
        req_t  seen;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (tag_results.size() == 0)
                    note_mismatch("result with nothing pending", 64'(done), 64'(0));
                else
                begin
                    want = tag_results.pop_front();
                    if (hit !== want.hit)
                        note_mismatch("hit", 64'(hit), 64'(want.hit));
                    if (way !== want.way)
                        note_mismatch("way", 64'(way), 64'(want.way));
                    if (evicted !== want.evicted)
                        note_mismatch("evicted", 64'(evicted), 64'(want.evicted));
                    if (evicted_tag !== want.ev_tag)
                        note_mismatch("evicted_tag", 64'(evicted_tag), 64'(want.ev_tag));
                    if (evicted_index !== want.ev_index)
                        note_mismatch("evicted_index", 64'(evicted_index),
                                      64'(want.ev_index));
                    if (evicted_context !== want.ev_ctx)
                        note_mismatch("evicted_context", 64'(evicted_context),
                                      64'(want.ev_ctx));
                end
            end
            if (cfg_we)
            begin
                case (rsct_pkg::cfg_reg_t'(cfg_addr))
                    rsct_pkg::CFG_EXTRA_BITS: map_extra = cfg_wdata[EXTRA_W-1:0];
                    rsct_pkg::CFG_SEED:
                        victim_lfsr = (cfg_wdata == '0) ? 16'd1 : cfg_wdata;
                    default: ;
                endcase
            end
            beat_taken = start && !busy;
            if (beat_taken)
            begin
                seen.op     = kind;
                seen.addr   = address;
                seen.ctx_id = context_id;
                seen.sec    = secure;
                seen.glob   = global_access;
                want = predict_access(seen);
                tag_results.push_back(want);
                beats_seen++;
                if (want.hit)     hits_seen++;
                if (want.evicted) evicts_seen++;
            end
        end
    end

    function automatic req_t mk(rsct_pkg::kind_t op, logic [47:0] a, logic [7:0] c,
                                bit s, bit g);
        req_t r;
        r.op = op;
        r.addr = a;
        r.ctx_id = c;
        r.sec = s;
        r.glob = g;
        r.drain_first = 1'b0;
        return r;
    endfunction

    function automatic req_t pool_req(int k, int t, rsct_pkg::kind_t op);
        bit [ADDR_BITS_DEF-1:0] a;
        bit [IDX_W-1:0]         ix;
        ix = pool_idx[k] & IDX_W'((1 << gen_nidx) - 1);
        a = (pool_tag[k][t] << (OFF_W + gen_nidx)) | (48'(ix) << OFF_W) |
            48'($urandom_range(LINE_BYTES_DEF - 1));
        return mk(op, a, pool_glob[k] ? 8'($urandom) : pool_ctx[k], pool_sec[k], pool_glob[k]);
    endfunction

    task automatic queue_req(req_t r);
        if (phase_pushed == drain_at)
            r.drain_first = 1'b1;
        req_backlog.push_back(r);
        phase_pushed++;
    endtask

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (start || req_backlog.size() != 0 || tag_results.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic run_phase(bit [2:0] extra, bit [15:0] seed, int idle, int n, int pause_at);
        bit [15:0] wd;
        int        k;
        int        t;
        int        pick;
        wait_quiet();
        wd = 16'($urandom);
        wd[2:0] = extra;
        cfg_we    <= 1'b1;
        cfg_addr  <= rsct_pkg::CFG_EXTRA_BITS;
        cfg_wdata <= wd;
        @(negedge clk);
        cfg_addr  <= rsct_pkg::CFG_SEED;
        cfg_wdata <= seed;
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_seen++;
        idle_pct = idle;
        gen_nidx = WAY_W + ((extra > EXTRA_MAX) ? EXTRA_MAX : int'(extra));
        for (int i = 0; i < POOL_KEYS; i++)
        begin
            pool_ctx[i]  = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom);
            pool_sec[i]  = 1'($urandom);
            pool_glob[i] = ($urandom_range(4) == 0);
            pool_idx[i]  = IDX_W'($urandom);
            for (int j = 0; j < POOL_TAGS; j++)
                pool_tag[i][j] = {16'($urandom), 32'($urandom)};
        end
        phase_pushed = 0;
        drain_at = pause_at;
        while (phase_pushed < n)
        begin
            k = $urandom_range(POOL_KEYS - 1);
            t = $urandom_range(POOL_TAGS - 1);
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                queue_req(pool_req(k, t, rsct_pkg::KIND_LOOKUP));
                queue_req(pool_req(k, t, rsct_pkg::KIND_FILL));
                queue_req(pool_req(k, t, rsct_pkg::KIND_LOOKUP));
            end
            else if (pick < 65)
                queue_req(pool_req(k, t, rsct_pkg::KIND_LOOKUP));
            else if (pick < 80)
                queue_req(pool_req(k, t, rsct_pkg::KIND_FILL));
            else if (pick < 92)
                queue_req(pool_req(k, t, rsct_pkg::KIND_INVAL));
            else if (pick < 95)
                queue_req(pool_req(k, t, rsct_pkg::KIND_NOP));
            else
                queue_req(mk(rsct_pkg::kind_t'($urandom_range(3)),
                             {16'($urandom), 32'($urandom)},
                             8'($urandom), 1'($urandom), 1'($urandom)));
        end
    endtask

    initial
    begin
        logic [47:0] a_zero;
        logic [47:0] a_same_idx;
        logic [47:0] a_ones;
        logic [47:0] a_glob;
        a_zero     = 48'h0000_0000_0000;
        a_same_idx = 48'h0000_1000_0000;
        a_ones     = 48'hFFFF_FFFF_FFFF;
        a_glob     = 48'h1234_5678_9AC0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed beats at reset configuration
        req_backlog.push_back(mk(rsct_pkg::KIND_LOOKUP, a_zero, 8'h00, 1'b0, 1'b0));
        req_backlog.push_back(mk(rsct_pkg::KIND_FILL, a_zero, 8'h00, 1'b0, 1'b0));
        req_backlog.push_back(mk(rsct_pkg::KIND_LOOKUP, a_zero + 48'd5, 8'h00, 1'b0, 1'b0));
        req_backlog.push_back(mk(rsct_pkg::KIND_LOOKUP, a_same_idx, 8'h00, 1'b0, 1'b0));
        req_backlog.push_back(mk(rsct_pkg::KIND_INVAL, a_same_idx, 8'h00, 1'b0, 1'b0));
        req_backlog.push_back(mk(rsct_pkg::KIND_FILL, a_same_idx, 8'h00, 1'b0, 1'b0));
        req_backlog.push_back(mk(rsct_pkg::KIND_LOOKUP, a_zero, 8'h00, 1'b0, 1'b0));
        req_backlog.push_back(mk(rsct_pkg::KIND_FILL, a_ones, 8'hFF, 1'b1, 1'b0));
        req_backlog.push_back(mk(rsct_pkg::KIND_LOOKUP, a_ones, 8'hFF, 1'b1, 1'b0));
        req_backlog.push_back(mk(rsct_pkg::KIND_LOOKUP, a_ones, 8'hFF, 1'b0, 1'b0));
        req_backlog.push_back(mk(rsct_pkg::KIND_LOOKUP, a_ones, 8'hFE, 1'b1, 1'b0));
        req_backlog.push_back(mk(rsct_pkg::KIND_LOOKUP, a_ones, 8'hFF, 1'b1, 1'b1));
        req_backlog.push_back(mk(rsct_pkg::KIND_FILL, a_glob, 8'hAB, 1'b0, 1'b1));
        req_backlog.push_back(mk(rsct_pkg::KIND_LOOKUP, a_glob, 8'h12, 1'b0, 1'b1));
        req_backlog.push_back(mk(rsct_pkg::KIND_LOOKUP, a_glob, 8'h00, 1'b0, 1'b0));
        req_backlog.push_back(mk(rsct_pkg::KIND_INVAL, a_ones, 8'hFF, 1'b1, 1'b0));
        req_backlog.push_back(mk(rsct_pkg::KIND_LOOKUP, a_ones, 8'hFF, 1'b1, 1'b0));
        req_backlog.push_back(mk(rsct_pkg::KIND_INVAL, a_ones, 8'hFF, 1'b1, 1'b0));
        req_backlog.push_back(mk(rsct_pkg::KIND_NOP, a_ones, 8'hFF, 1'b1, 1'b1));
        req_backlog.push_back(mk(rsct_pkg::KIND_INVAL, a_glob, 8'h00, 1'b0, 1'b0));
        req_backlog.push_back(mk(rsct_pkg::KIND_FILL, a_ones, 8'h00, 1'b0, 1'b1));
        req_backlog.push_back(mk(rsct_pkg::KIND_FILL, a_zero, 8'h7F, 1'b1, 1'b0));

        run_phase(3'd4, 16'hFFFF, 0, 300, -1);
        run_phase(3'd0, 16'h0000, 49, 300, 150);
        run_phase(3'd7, 16'($urandom_range(1, 65535)), 9, 300, -1);
        run_phase(3'd2, 16'($urandom_range(1, 65535)), 0, 300, -1);
        run_phase(3'd5, 16'($urandom_range(1, 65535)), 49, 400, 150);
        wait_quiet();
        repeat (6) @(negedge clk);

        $display("covered %0d beats over %0d register settings plus reset defaults",
                 beats_seen, settings_seen);
        $display("  %0d hits, %0d evictions checked", hits_seen, evicts_seen);
        if (err_count == 0)
            $display("remapped_secure_cache_tags_core test passed");
        else
            $display("remapped_secure_cache_tags_core test failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("timeout waiting for results");
        $display("remapped_secure_cache_tags_core test failed");
        $finish;
    end

endmodule
